>>> rtl/core/mtp_pkg.sv
package mtp_pkg;

  localparam int unsigned STATE_DEPTH  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned ADDR_W       = $clog2(STATE_DEPTH);
  localparam int unsigned WORD_W       = 32;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(STATE_DEPTH - 1);
  localparam logic [ADDR_W:0]   OFFSET_W = (ADDR_W + 1)'(TWIST_OFFSET);
  localparam logic [ADDR_W:0]   DEPTH_W  = (ADDR_W + 1)'(STATE_DEPTH);

  localparam logic [WORD_W-1:0] MT_MATRIX   = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] MT_INIT_MUL = 32'd1812433253;
  localparam logic [WORD_W-1:0] MT_SEED_RST = 32'd5489;
  localparam logic [WORD_W-1:0] TEMPER_B    = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C    = 32'hefc6_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_READ,
    ST_CALC
  } mtp_state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mtp_ram_ctrl_t;

endpackage

>>> rtl/core/mersenne_twister_prng_top.sv
// MT19937 generator: each request item returns one tempered 32-bit word on
// out_tdata. The 624-word state sits in one RAM with a write port and two
// registered read ports. The first request after reset, and any request with
// restart set, seeds the state from the seed register first, all 624 words,
// one word a cycle through the seeding multiplier, then produces the word
// itself. Each request is accepted, reads the RAM, then is twisted and
// tempered into the output register once that is free. The twist runs
// lazily, one state word per item, in the same order as a full in-place
// twist, so the sequence is identical. The word at the current position is
// held in a register, so only the next and the far word are read per item.
// A result waits in the output register while the next item is accepted;
// seed writes take effect at the next seeding.
module mersenne_twister_prng_top (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] restart, [7:1] zero
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] random_word
  // seed register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data    // [31:0] seed_value
);

  localparam int unsigned AW = mtp_pkg::ADDR_W;
  localparam int unsigned WW = mtp_pkg::WORD_W;

  mtp_pkg::mtp_state_t    state_r, state_nxt;
  mtp_pkg::mtp_ram_ctrl_t ram_ctrl;

  logic [WW-1:0] seed_r;
  logic [AW-1:0] cnt_r;       // seeding index
  logic [AW-1:0] pos_r;       // next state word to use
  logic          seeded_r;
  logic [WW-1:0] cur_r;       // current (untwisted) content of word pos_r
  logic          out_valid_r;
  logic [WW-1:0] out_data_r;

  logic          in_fire;
  logic          out_free;
  logic          seed_done;
  logic [AW-1:0] pos_next;
  logic [AW:0]   far_sum;
  logic [AW-1:0] far_idx;
  logic [WW-1:0] seed_word;
  logic [WW-1:0] rd_next;
  logic [WW-1:0] rd_far;
  logic [WW-1:0] twisted;
  logic [WW-1:0] tempered;

  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign seed_done = (cnt_r == mtp_pkg::LAST_IDX);
  assign cfg_ready = 1'b1;

  // wrap the neighbour and far indices
  assign pos_next = (pos_r == mtp_pkg::LAST_IDX) ? '0 : pos_r + AW'(1);
  assign far_sum  = {1'b0, pos_r} + mtp_pkg::OFFSET_W;
  assign far_idx  = (far_sum >= mtp_pkg::DEPTH_W) ? AW'(far_sum - mtp_pkg::DEPTH_W)
                                                  : far_sum[AW-1:0];

  mtp_ram u_ram (
    .clk     (clk),
    .ctrl    (ram_ctrl),
    .rdata_a (rd_next),
    .rdata_b (rd_far)
  );

  mtp_seed_gen u_seed (
    .clk  (clk),
    .en   (state_r == mtp_pkg::ST_SEED),
    .idx  (cnt_r),
    .seed (seed_r),
    .word (seed_word)
  );

  mtp_twist_temper u_twist (
    .cur_word  (cur_r),
    .next_word (rd_next),
    .far_word  (rd_far),
    .twisted   (twisted),
    .tempered  (tempered)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mtp_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_tdata[0] || !seeded_r) ? mtp_pkg::ST_SEED : mtp_pkg::ST_READ;
        end
      end
      mtp_pkg::ST_SEED: begin
        if (seed_done) begin
          state_nxt = mtp_pkg::ST_READ;
        end
      end
      mtp_pkg::ST_READ: state_nxt = mtp_pkg::ST_CALC;
      mtp_pkg::ST_CALC: begin
        if (out_free) begin
          state_nxt = mtp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mtp_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake and RAM control
  always_comb begin
    in_tready        = 1'b0;
    ram_ctrl.we      = 1'b0;
    ram_ctrl.waddr   = pos_r;
    ram_ctrl.wdata   = twisted;
    ram_ctrl.re      = 1'b0;
    ram_ctrl.raddr_a = pos_next;
    ram_ctrl.raddr_b = far_idx;
    unique case (state_r)
      mtp_pkg::ST_IDLE: in_tready = 1'b1;
      mtp_pkg::ST_SEED: begin
        ram_ctrl.we    = 1'b1;
        ram_ctrl.waddr = cnt_r;
        ram_ctrl.wdata = seed_word;
      end
      mtp_pkg::ST_READ: ram_ctrl.re = 1'b1;
      mtp_pkg::ST_CALC: ram_ctrl.we = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtp_pkg::ST_IDLE;
      seed_r      <= mtp_pkg::MT_SEED_RST;
      cnt_r       <= '0;
      pos_r       <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        seed_r <= cfg_data;
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        mtp_pkg::ST_IDLE: cnt_r <= '0;
        mtp_pkg::ST_SEED: begin
          cnt_r <= cnt_r + AW'(1);
          if (seed_done) begin
            pos_r    <= '0;
            seeded_r <= 1'b1;
          end
        end
        mtp_pkg::ST_CALC: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            pos_r       <= pos_next;
          end
        end
        default: ;
      endcase
    end
  end

  // payload: held word and result register
  always_ff @(posedge clk) begin
    if (state_r == mtp_pkg::ST_SEED && cnt_r == '0) begin
      cur_r <= seed_r;
    end else if (state_r == mtp_pkg::ST_CALC && out_free) begin
      cur_r <= rd_next;
    end
    if (state_r == mtp_pkg::ST_CALC && out_free) begin
      out_data_r <= tempered;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an unseeded generator must seed before producing a word
  a_seed_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !seeded_r) |=> (state_r == mtp_pkg::ST_SEED))
    else $error("request on unseeded state skipped seeding");

  // seeding ends at word zero with the state marked seeded
  a_seed_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtp_pkg::ST_SEED && seed_done) |=> (seeded_r && pos_r == '0))
    else $error("seeding did not finish at word zero");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtp_pkg::ST_CALC && out_valid_r && !out_tready)
      |=> (state_r == mtp_pkg::ST_CALC && $stable(out_data_r)))
    else $error("result register overwritten while stalled");

  // reads and writes of the state RAM never share a cycle
  a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_ctrl.we && ram_ctrl.re))
    else $error("state RAM read and written in the same cycle");

endmodule

>>> rtl/core/mtp_ram.sv
module mtp_ram (
  input  logic                                clk,
  input  mtp_pkg::mtp_ram_ctrl_t              ctrl,
  output logic [mtp_pkg::WORD_W-1:0]          rdata_a,
  output logic [mtp_pkg::WORD_W-1:0]          rdata_b
);

  logic [mtp_pkg::WORD_W-1:0] mem [mtp_pkg::STATE_DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[ctrl.waddr] <= ctrl.wdata;
    end
    if (ctrl.re) begin
      rdata_a <= mem[ctrl.raddr_a];
      rdata_b <= mem[ctrl.raddr_b];
    end
  end

endmodule

>>> rtl/core/mtp_seed_gen.sv
module mtp_seed_gen (
  input  logic                                clk,
  input  logic                                en,
  input  logic [mtp_pkg::ADDR_W-1:0]          idx,
  input  logic [mtp_pkg::WORD_W-1:0]          seed,
  output logic [mtp_pkg::WORD_W-1:0]          word
);

  logic [mtp_pkg::WORD_W-1:0] prev_r;
  logic [mtp_pkg::WORD_W-1:0] mixed;
  logic [mtp_pkg::WORD_W-1:0] prod;

  // word[k] = MUL * (word[k-1] ^ (word[k-1] >> 30)) + k, low 32 bits
  assign mixed = prev_r ^ (prev_r >> 30);
  assign prod  = mtp_pkg::WORD_W'(mtp_pkg::MT_INIT_MUL * mixed);
  assign word  = (idx == '0) ? seed
                             : prod + mtp_pkg::WORD_W'(idx);

  always_ff @(posedge clk) begin
    if (en) begin
      prev_r <= word;
    end
  end

endmodule

>>> rtl/core/mtp_twist_temper.sv
module mtp_twist_temper (
  input  logic [mtp_pkg::WORD_W-1:0] cur_word,
  input  logic [mtp_pkg::WORD_W-1:0] next_word,
  input  logic [mtp_pkg::WORD_W-1:0] far_word,
  output logic [mtp_pkg::WORD_W-1:0] twisted,
  output logic [mtp_pkg::WORD_W-1:0] tempered
);

  logic [mtp_pkg::WORD_W-1:0] h;
  logic [mtp_pkg::WORD_W-1:0] t1;
  logic [mtp_pkg::WORD_W-1:0] t2;
  logic [mtp_pkg::WORD_W-1:0] t3;

  always_comb begin
    h       = {cur_word[31], next_word[30:0]};
    twisted = far_word ^ (h >> 1) ^ (h[0] ? mtp_pkg::MT_MATRIX : '0);
    t1       = twisted ^ (twisted >> 11);
    t2       = t1 ^ ((t1 << 7) & mtp_pkg::TEMPER_B);
    t3       = t2 ^ ((t2 << 15) & mtp_pkg::TEMPER_C);
    tempered = t3 ^ (t3 >> 18);
  end

endmodule
